@@ sv/gbce_pkg.sv @@
// shared types, constants and functions of the glyph color-expand blitter
// no dependencies; imported by every module of the block
package gbce_pkg;

	localparam int COORD_BITS     = 12;
	localparam int GLYPH_DIM_BITS = 8;
	localparam int ADDR_BITS      = 26;
	localparam int COLOR_BITS     = 24;
	localparam int LINE_BITS      = 15;
	localparam int DEPTH_BITS     = 2;
	localparam int QUEUE_DEPTH    = 4;

	// column index within a row, 8 pixels per source byte
	localparam int COL_BITS = GLYPH_DIM_BITS + 3;
	localparam int Y_BITS   = ((COORD_BITS > GLYPH_DIM_BITS) ? COORD_BITS : GLYPH_DIM_BITS) + 1;
	localparam int X_BITS   = ((COORD_BITS > COL_BITS) ? COORD_BITS : COL_BITS) + 1;
	localparam int PROD_BITS = Y_BITS + LINE_BITS;
	localparam int MUL_BITS  = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

	// frame buffer formats
	localparam logic [DEPTH_BITS-1:0] DEPTH_8BPP  = 2'd0;
	localparam logic [DEPTH_BITS-1:0] DEPTH_16BPP = 2'd1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_32BPP = 2'd2;

	// write size codes
	localparam logic [1:0] SIZE_1 = 2'd0;
	localparam logic [1:0] SIZE_2 = 2'd1;
	localparam logic [1:0] SIZE_4 = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FOREGROUND = 2'd0;
	localparam logic [1:0] REG_BACKGROUND = 2'd1;
	localparam logic [1:0] REG_DEPTH      = 2'd2;
	localparam logic [1:0] REG_LINE_BYTES = 2'd3;

	localparam logic [COLOR_BITS-1:0] FOREGROUND_RESET = 24'hFFFFFF;
	localparam logic [COLOR_BITS-1:0] BACKGROUND_RESET = 24'h000000;
	localparam logic [LINE_BITS-1:0]  LINE_BYTES_RESET = 15'd4096;

	typedef struct packed {
		logic                      glyph_start;
		logic [COORD_BITS-1:0]     origin_x;
		logic [COORD_BITS-1:0]     origin_y;
		logic [GLYPH_DIM_BITS-1:0] glyph_width;
		logic [GLYPH_DIM_BITS-1:0] glyph_height;
		logic [GLYPH_DIM_BITS-1:0] row_pitch;
		logic                      source_is_bytes;
		logic [7:0]                bitmap_byte;
	} glyph_in_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] pixel_address;
		logic [31:0]          pixel_value;
		logic [1:0]           write_size;
		logic                 last_of_byte;
		logic                 glyph_done;
	} pix_out_t;

	// one classified source byte, front to back
	typedef struct packed {
		logic [Y_BITS-1:0] y;
		logic [X_BITS-1:0] x_first;
		logic [7:0]        bits;
		logic [2:0]        count_m1;
		logic              done_hit;
		logic [2:0]        done_k;
	} cmd_t;

	function automatic logic [31:0] format_color(logic [COLOR_BITS-1:0] c,
		logic [DEPTH_BITS-1:0] mode);
		case (mode)
			DEPTH_8BPP:  return {24'd0, c[7:0]};
			DEPTH_16BPP: return {16'd0, c[23:19], c[15:10], c[7:3]};
			default:     return {8'd0, c};
		endcase
	endfunction

	function automatic logic [1:0] size_code(logic [DEPTH_BITS-1:0] mode);
		case (mode)
			DEPTH_8BPP:  return SIZE_1;
			DEPTH_16BPP: return SIZE_2;
			default:     return SIZE_4;
		endcase
	endfunction

endpackage

@@ sv/glyph_bitmap_color_expand_blit.sv @@
// Glyph color-expand blitter. Source bytes arrive on the glyph channel, one beat per byte;
// a beat with glyph_start set also loads the placement, size, row pitch and source format.
// Each byte becomes pixel writes on the pix channel: up to eight for a 1-bit source, one for
// an 8-bit source, none for padding bytes or bytes past the glyph. The back end issues one
// pixel write per cycle while pix_ready does not stall the output register; the glyph channel
// takes a beat every cycle while the four-entry command queue has room. An accepted byte
// passes through the command queue and the s1, s2 and output registers before its first write.
// Colors, depth mode and line byte count sit in APB registers at 0x0, 0x4, 0x8 and 0xC;
// write them only while idle.
// depends on gbce_pkg, gbce_front, gbce_queue, gbce_back
module glyph_bitmap_color_expand_blit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                glyph_valid,
	output logic                glyph_ready,
	input  gbce_pkg::glyph_in_t glyph,
	output logic                pix_valid,
	input  logic                pix_ready,
	output gbce_pkg::pix_out_t  pix
);
	import gbce_pkg::*;

	logic [COLOR_BITS-1:0] fg_q, bg_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [LINE_BITS-1:0]  line_q;
	logic                  cfg_write;
	logic [1:0]            reg_idx;

	logic                  push, pop, full, empty;
	cmd_t                  push_cmd, head;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q    <= FOREGROUND_RESET;
			bg_q    <= BACKGROUND_RESET;
			depth_q <= DEPTH_32BPP;
			line_q  <= LINE_BYTES_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FOREGROUND: fg_q    <= pwdata[COLOR_BITS-1:0];
				REG_BACKGROUND: bg_q    <= pwdata[COLOR_BITS-1:0];
				REG_DEPTH:      depth_q <= pwdata[DEPTH_BITS-1:0];
				REG_LINE_BYTES: line_q  <= pwdata[LINE_BITS-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FOREGROUND: prdata = 32'(fg_q);
			REG_BACKGROUND: prdata = 32'(bg_q);
			REG_DEPTH:      prdata = 32'(depth_q);
			REG_LINE_BYTES: prdata = 32'(line_q);
			default:        prdata = '0;
		endcase
	end

	gbce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_valid (glyph_valid),
		.glyph_ready (glyph_ready),
		.glyph       (glyph),
		.queue_full  (full),
		.push        (push),
		.cmd         (push_cmd)
	);

	gbce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	gbce_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.queue_empty      (empty),
		.head             (head),
		.pop              (pop),
		.foreground_color (fg_q),
		.background_color (bg_q),
		.video_depth_mode (depth_q),
		.line_byte_count  (line_q),
		.pix_valid        (pix_valid),
		.pix_ready        (pix_ready),
		.pix              (pix)
	);

endmodule

@@ sv/gbce_front.sv @@
// front end: glyph geometry state, classifies each source byte into a command
// depends on gbce_pkg
module gbce_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              glyph_valid,
	output logic              glyph_ready,
	input  gbce_pkg::glyph_in_t glyph,
	input  logic              queue_full,
	output logic              push,
	output gbce_pkg::cmd_t    cmd
);
	import gbce_pkg::*;

	logic [COORD_BITS-1:0]     base_x_q, base_y_q;
	logic [GLYPH_DIM_BITS-1:0] width_q, height_q, pitch_q, row_q, bir_q;
	logic                      bytes_mode_q;

	logic [COORD_BITS-1:0]     bx, by;
	logic [GLYPH_DIM_BITS-1:0] w, h, p, row, bir;
	logic                      bm, active, has_pix, accept;
	logic [COL_BITS-1:0]       first, covered, cols, avail, diff, n;
	logic [GLYPH_DIM_BITS:0]   bir_next;

	assign glyph_ready = !queue_full;
	assign accept      = glyph_valid && glyph_ready;

	always_comb begin
		if (glyph.glyph_start) begin
			bx  = glyph.origin_x;
			by  = glyph.origin_y;
			w   = glyph.glyph_width;
			h   = glyph.glyph_height;
			p   = (glyph.row_pitch == '0) ? GLYPH_DIM_BITS'(1) : glyph.row_pitch;
			bm  = glyph.source_is_bytes;
			row = '0;
			bir = '0;
		end else begin
			bx  = base_x_q;
			by  = base_y_q;
			w   = width_q;
			h   = height_q;
			p   = pitch_q;
			bm  = bytes_mode_q;
			row = row_q;
			bir = bir_q;
		end
		active  = row < h;
		first   = bm ? COL_BITS'(bir) : {bir, 3'b000};
		covered = bm ? COL_BITS'(p) : {p, 3'b000};
		cols    = (COL_BITS'(w) < covered) ? COL_BITS'(w) : covered;
		has_pix = active && (COL_BITS'(w) > first);
		avail   = COL_BITS'(w) - first;
		if (bm)
			n = COL_BITS'(1);
		else
			n = (avail < COL_BITS'(8)) ? avail : COL_BITS'(8);
		diff    = cols - COL_BITS'(1) - first;
		bir_next = {1'b0, bir} + 1'b1;

		cmd.y        = Y_BITS'(by) + Y_BITS'(row);
		cmd.x_first  = X_BITS'(bx) + X_BITS'(first);
		cmd.bits     = bm ? {(glyph.bitmap_byte != 8'd0), 7'd0} : glyph.bitmap_byte;
		cmd.count_m1 = 3'(n - COL_BITS'(1));
		cmd.done_hit = (({1'b0, row} + 1'b1) == {1'b0, h}) && (diff < n);
		cmd.done_k   = diff[2:0];
		push         = accept && has_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q     <= '0;
			base_y_q     <= '0;
			width_q      <= '0;
			height_q     <= '0;
			pitch_q      <= GLYPH_DIM_BITS'(1);
			bytes_mode_q <= 1'b0;
			row_q        <= '0;
			bir_q        <= '0;
		end else if (accept) begin
			base_x_q     <= bx;
			base_y_q     <= by;
			width_q      <= w;
			height_q     <= h;
			pitch_q      <= p;
			bytes_mode_q <= bm;
			row_q        <= row;
			bir_q        <= bir;
			if (active) begin
				if (bir_next >= {1'b0, p}) begin
					bir_q <= '0;
					row_q <= row + 1'b1;
				end else begin
					bir_q <= bir_next[GLYPH_DIM_BITS-1:0];
				end
			end
		end
	end

endmodule

@@ sv/gbce_queue.sv @@
// short command queue between front and back, show-ahead head
// depends on gbce_pkg
module gbce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gbce_pkg::cmd_t push_cmd,
	input  logic           pop,
	output gbce_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import gbce_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	cmd_t                  slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]     count_q;

	assign full  = (count_q == (PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/gbce_back.sv @@
// back end: row term multiply, then one pixel write per cycle, unless pix_ready stalls it, into an output register
// depends on gbce_pkg
module gbce_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            queue_empty,
	input  gbce_pkg::cmd_t                  head,
	output logic                            pop,
	input  logic [gbce_pkg::COLOR_BITS-1:0] foreground_color,
	input  logic [gbce_pkg::COLOR_BITS-1:0] background_color,
	input  logic [gbce_pkg::DEPTH_BITS-1:0] video_depth_mode,
	input  logic [gbce_pkg::LINE_BITS-1:0]  line_byte_count,
	output logic                            pix_valid,
	input  logic                            pix_ready,
	output gbce_pkg::pix_out_t              pix
);
	import gbce_pkg::*;

	cmd_t                 cmd_s1, cmd_s2;
	logic [ADDR_BITS-1:0] row_s1, row_s2;
	logic                 valid_s1, valid_s2;
	logic [2:0]           k_q;
	pix_out_t             pix_q;
	logic                 pix_valid_q;

	logic                 out_free, emit, it_done, it_load, set;
	logic [MUL_BITS-1:0]  prod;
	logic [X_BITS:0]      xk;
	logic [ADDR_BITS-1:0] x_term;
	logic [COLOR_BITS-1:0] color;
	pix_out_t             pix_next;

	assign out_free = !pix_valid_q || pix_ready;
	assign emit     = valid_s2 && out_free;
	assign it_done  = emit && (k_q == cmd_s2.count_m1);
	assign it_load  = valid_s1 && (!valid_s2 || it_done);
	assign pop      = !queue_empty && (!valid_s1 || it_load);
	assign prod     = MUL_BITS'(head.y) * MUL_BITS'(line_byte_count);

	always_comb begin
		xk  = (X_BITS+1)'(cmd_s2.x_first) + (X_BITS+1)'(k_q);
		case (video_depth_mode)
			DEPTH_8BPP:  x_term = ADDR_BITS'(xk);
			DEPTH_16BPP: x_term = ADDR_BITS'({xk, 1'b0});
			default:     x_term = ADDR_BITS'({xk, 2'b00});
		endcase
		// msb first across the byte
		set   = cmd_s2.bits[3'd7 - k_q];
		color = set ? foreground_color : background_color;
		pix_next.pixel_address = row_s2 + x_term;
		pix_next.pixel_value   = format_color(color, video_depth_mode);
		pix_next.write_size    = size_code(video_depth_mode);
		pix_next.last_of_byte  = (k_q == cmd_s2.count_m1);
		pix_next.glyph_done    = cmd_s2.done_hit && (k_q == cmd_s2.done_k);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
			row_s1 <= prod[ADDR_BITS-1:0];
		end
		if (it_load) begin
			cmd_s2 <= cmd_s1;
			row_s2 <= row_s1;
		end
		if (emit)
			pix_q <= pix_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			k_q         <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (pop)
				valid_s1 <= 1'b1;
			else if (it_load)
				valid_s1 <= 1'b0;
			if (it_load) begin
				valid_s2 <= 1'b1;
				k_q      <= '0;
			end else if (it_done) begin
				valid_s2 <= 1'b0;
			end else if (emit) begin
				k_q <= k_q + 1'b1;
			end
			if (out_free)
				pix_valid_q <= emit;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

@@ sv/gbce_checker.sv @@
// port-level checks of the blitter's pixel write channel, bound to the top level
// depends on gbce_pkg and glyph_bitmap_color_expand_blit
module gbce_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_ready,
	input gbce_pkg::pix_out_t pix
);
	import gbce_pkg::*;

	// nothing offered while in reset; the flops may still be unknown at the very first edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !pix_valid)
		else $error("pixel beat during reset");

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("stalled pixel beat changed");

	// the glyph's final write always closes its source byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.glyph_done |-> pix.last_of_byte)
		else $error("glyph_done without last_of_byte");

	// the color never spills past the write size
	a_size_value: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix.pixel_value[31:24] == 8'd0)
			&& (pix.write_size != SIZE_1 || pix.pixel_value[23:8] == 16'd0)
			&& (pix.write_size != SIZE_2 || pix.pixel_value[23:16] == 8'd0)
			&& (pix.write_size == SIZE_1 || pix.write_size == SIZE_2
				|| pix.write_size == SIZE_4))
		else $error("pixel value wider than write size");

endmodule

bind glyph_bitmap_color_expand_blit gbce_checker u_gbce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.pix       (pix)
);

@@ test/glyph_bitmap_color_expand_blit_tb.sv @@
// self-checking testbench for the glyph color-expand blitter: byte beats in, pixel writes out
// depends on gbce_pkg and glyph_bitmap_color_expand_blit; registers go through the apb port
module glyph_bitmap_color_expand_blit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbce_pkg::*;

	localparam logic [DEPTH_BITS-1:0] DEPTH_SPARE = 2'd3;
	localparam int SETTLE_CYCLES    = 16;
	localparam int HOLD_CYCLES      = 300;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int BYTES_PER_PHASE  = 82;
	localparam int REPORT_LIMIT     = 10;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        glyph_valid = 1'b0;
	logic        glyph_ready;
	glyph_in_t   glyph = '0;
	logic        pix_valid;
	logic        pix_ready = 1'b0;
	pix_out_t    pix;

	glyph_bitmap_color_expand_blit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.glyph_valid (glyph_valid),
		.glyph_ready (glyph_ready),
		.glyph       (glyph),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix)
	);

	// register shadows
	logic [COLOR_BITS-1:0] fg_color   = FOREGROUND_RESET;
	logic [COLOR_BITS-1:0] bg_color   = BACKGROUND_RESET;
	logic [DEPTH_BITS-1:0] depth_mode = DEPTH_32BPP;
	logic [LINE_BITS-1:0]  line_bytes = LINE_BYTES_RESET;

	// glyph geometry and walk position as the block should hold them
	logic [COORD_BITS-1:0]     org_x    = '0;
	logic [COORD_BITS-1:0]     org_y    = '0;
	logic [GLYPH_DIM_BITS-1:0] g_width  = '0;
	logic [GLYPH_DIM_BITS-1:0] g_height = '0;
	logic [GLYPH_DIM_BITS-1:0] g_pitch  = GLYPH_DIM_BITS'(1);
	logic                      g_bytes  = 1'b0;
	logic [GLYPH_DIM_BITS-1:0] row_now  = '0;
	logic [GLYPH_DIM_BITS-1:0] byte_now = '0;

	glyph_in_t glyph_bytes_todo[$];
	pix_out_t  expected_writes[$];

	int  mismatch_count = 0;
	int  writes_checked = 0;
	int  tx_gap = 0;
	int  rx_wait = 0;
	int  quiet_cycles = 0;
	int  hold_req = 0;
	int  hold_seen = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] frame_color(logic [COLOR_BITS-1:0] rgb,
		logic [DEPTH_BITS-1:0] mode);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		r5 = rgb[23:19];
		g6 = rgb[15:10];
		b5 = rgb[7:3];
		if (mode == DEPTH_8BPP)
			return {24'd0, rgb[7:0]};
		if (mode == DEPTH_16BPP)
			return {16'd0, r5, g6, b5};
		return {8'd0, rgb};
	endfunction

	// turns one accepted byte beat into the pixel writes it should cause
	function automatic void expand_glyph_byte(glyph_in_t b);
		int unsigned     per_byte, bpp, covered, cols, first_col, col, k;
		longint unsigned y_pix, x_pix, addr_full;
		logic [1:0]      wsize;
		logic            lit;
		pix_out_t        w;
		int              n;
		if (b.glyph_start) begin
			org_x    = b.origin_x;
			org_y    = b.origin_y;
			g_width  = b.glyph_width;
			g_height = b.glyph_height;
			g_pitch  = (b.row_pitch == 0) ? 8'd1 : b.row_pitch;
			g_bytes  = b.source_is_bytes;
			row_now  = '0;
			byte_now = '0;
		end
		// past the last row, or nothing started yet
		if (row_now >= g_height)
			return;
		per_byte = g_bytes ? 1 : 8;
		case (depth_mode)
			DEPTH_8BPP: begin
				bpp = 1;
				wsize = SIZE_1;
			end
			DEPTH_16BPP: begin
				bpp = 2;
				wsize = SIZE_2;
			end
			default: begin
				bpp = 4;
				wsize = SIZE_4;
			end
		endcase
		// a short pitch leaves the right columns uncovered
		covered = g_pitch * per_byte;
		cols = (g_width < covered) ? g_width : covered;
		first_col = byte_now * per_byte;
		y_pix = org_y + row_now;
		n = 0;
		for (k = 0; k < per_byte; k++) begin
			col = first_col + k;
			if (col >= g_width)
				break;
			lit = g_bytes ? (b.bitmap_byte != 0) : b.bitmap_byte[7 - k];
			x_pix = org_x + col;
			addr_full = y_pix * line_bytes + x_pix * bpp;
			w.pixel_address = addr_full[ADDR_BITS-1:0];
			w.pixel_value = frame_color(lit ? fg_color : bg_color, depth_mode);
			w.write_size = wsize;
			w.last_of_byte = 1'b0;
			w.glyph_done = (row_now + 1 == g_height) && (col + 1 == cols);
			expected_writes.push_back(w);
			n++;
		end
		if (n > 0) begin
			w = expected_writes.pop_back();
			w.last_of_byte = 1'b1;
			expected_writes.push_back(w);
		end
		byte_now = byte_now + 1'b1;
		if (byte_now >= g_pitch) begin
			byte_now = '0;
			row_now = row_now + 1'b1;
		end
	endfunction

	function automatic void check_write(pix_out_t got);
		pix_out_t want;
		if (expected_writes.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("unexpected pixel write: addr %h value %h size %0d last %b done %b",
					got.pixel_address, got.pixel_value, got.write_size,
					got.last_of_byte, got.glyph_done);
			mismatch_count++;
			return;
		end
		want = expected_writes.pop_front();
		if (got.pixel_address !== want.pixel_address || got.pixel_value !== want.pixel_value
			|| got.write_size !== want.write_size || got.last_of_byte !== want.last_of_byte
			|| got.glyph_done !== want.glyph_done) begin
			if (mismatch_count < REPORT_LIMIT) begin
				$display("pixel write %0d wrong: want addr %h value %h size %0d last %b done %b",
					writes_checked, want.pixel_address, want.pixel_value, want.write_size,
					want.last_of_byte, want.glyph_done);
				$display("                      got  addr %h value %h size %0d last %b done %b",
					got.pixel_address, got.pixel_value, got.write_size,
					got.last_of_byte, got.glyph_done);
			end
			mismatch_count++;
		end
		writes_checked++;
	endfunction

	function automatic int sender_gap();
		return tx_steady ? 0 : int'($urandom_range(0, 15));
	endfunction

	// byte beat driver
	always @(posedge clk) begin
		if (!arst_n) begin
			glyph_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (glyph_valid && glyph_ready)
				expand_glyph_byte(glyph);
			if (!glyph_valid || glyph_ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					glyph_valid <= 1'b0;
				end else if (glyph_bytes_todo.size() != 0) begin
					glyph <= glyph_bytes_todo.pop_front();
					glyph_valid <= 1'b1;
					tx_gap <= sender_gap();
				end else begin
					glyph_valid <= 1'b0;
				end
			end
		end
	end

	// pixel write monitor, with random and long back-pressure
	always @(posedge clk) begin : pixel_monitor
		int wait_n;
		if (!arst_n) begin
			pix_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			wait_n = rx_wait;
			if (pix_valid && pix_ready) begin
				check_write(pix);
				wait_n = rx_steady ? 0 : int'($urandom_range(0, 15));
			end
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				wait_n = HOLD_CYCLES;
			end
			if (wait_n > 0) begin
				pix_ready <= 1'b0;
				rx_wait <= wait_n - 1;
			end else begin
				pix_ready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (glyph_valid && glyph_ready) || (pix_valid && pix_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void push_byte(logic start, logic [COORD_BITS-1:0] x,
		logic [COORD_BITS-1:0] y, logic [GLYPH_DIM_BITS-1:0] w,
		logic [GLYPH_DIM_BITS-1:0] h, logic [GLYPH_DIM_BITS-1:0] pitch,
		logic bytes_src, logic [7:0] bits);
		glyph_in_t b;
		b.glyph_start     = start;
		b.origin_x        = x;
		b.origin_y        = y;
		b.glyph_width     = w;
		b.glyph_height    = h;
		b.row_pitch       = pitch;
		b.source_is_bytes = bytes_src;
		b.bitmap_byte     = bits;
		glyph_bytes_todo.push_back(b);
	endfunction

	// continuation beat: geometry fields carry junk that must be ignored
	function automatic void push_data(logic [7:0] bits);
		push_byte(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom),
			GLYPH_DIM_BITS'($urandom), GLYPH_DIM_BITS'($urandom),
			GLYPH_DIM_BITS'($urandom), 1'($urandom), bits);
	endfunction

	// one glyph, mostly well formed; returns the beats that belong to it
	function automatic int queue_random_glyph();
		logic bytes_src;
		int   per_byte, w, h, pitch, total, k, junk;
		bytes_src = 1'($urandom_range(0, 1));
		per_byte = bytes_src ? 1 : 8;
		w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 20);
		h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
		pitch = (w + per_byte - 1) / per_byte;
		if ($urandom_range(0, 4) == 0)
			pitch = $urandom_range(0, 4);
		if ($urandom_range(0, 15) == 0)
			pitch = $urandom_range(0, 255);
		total = h * ((pitch == 0) ? 1 : pitch);
		if (total == 0)
			total = 1;
		if (total > 24)
			total = 24;
		// cut short, the next start takes over mid-glyph
		if ($urandom_range(0, 9) == 0)
			total = $urandom_range(1, total);
		push_byte(1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom), GLYPH_DIM_BITS'(w),
			GLYPH_DIM_BITS'(h), GLYPH_DIM_BITS'(pitch), bytes_src, 8'($urandom));
		for (k = 1; k < total; k++)
			push_data(8'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			junk = $urandom_range(1, 3);
			for (k = 0; k < junk; k++)
				push_data(8'($urandom));
		end
		return total;
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (glyph_bytes_todo.size() != 0 || glyph_valid || expected_writes.size() != 0);
		// beats that make no writes may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FOREGROUND: fg_color = value[COLOR_BITS-1:0];
			REG_BACKGROUND: bg_color = value[COLOR_BITS-1:0];
			REG_DEPTH:      depth_mode = value[DEPTH_BITS-1:0];
			REG_LINE_BYTES: line_bytes = value[LINE_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] fg, logic [31:0] bg, logic [DEPTH_BITS-1:0] depth,
		logic [31:0] line_cnt);
		write_reg(REG_FOREGROUND, fg);
		write_reg(REG_BACKGROUND, bg);
		write_reg(REG_DEPTH, {30'd0, depth});
		write_reg(REG_LINE_BYTES, line_cnt);
	endtask

	initial begin
		int queued;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings
		// stray beats before any glyph are dropped
		push_data(8'hFF);
		push_data(8'h00);
		// zero width, then zero height, then a beat after that empty glyph
		push_byte(1'b1, 12'd100, 12'd50, 8'd0, 8'd3, 8'd1, 1'b0, 8'hFF);
		push_byte(1'b1, 12'd100, 12'd50, 8'd4, 8'd0, 8'd1, 1'b0, 8'hFF);
		push_data(8'hA5);
		// zero pitch acts as one byte per row; third beat lands past the end
		push_byte(1'b1, 12'd0, 12'd0, 8'd8, 8'd2, 8'd0, 1'b0, 8'hFF);
		push_data(8'h00);
		push_data(8'h3C);
		// far corner, wider than the pitch covers
		push_byte(1'b1, 12'd4095, 12'd4095, 8'd255, 8'd1, 8'd1, 1'b0, 8'hA5);
		// padding byte past the width
		push_byte(1'b1, 12'd10, 12'd20, 8'd5, 8'd1, 8'd2, 1'b0, 8'hF0);
		push_data(8'hFF);
		// byte source: zero and nonzero bytes, padding columns
		push_byte(1'b1, 12'd7, 12'd3, 8'd3, 8'd2, 8'd4, 1'b1, 8'h00);
		push_data(8'h80);
		push_data(8'h01);
		push_data(8'h55);
		push_data(8'h01);
		push_data(8'h00);
		push_data(8'hFF);
		push_data(8'h00);
		// tall and wide glyphs interrupted by the next start
		push_byte(1'b1, 12'd2048, 12'd1024, 8'd255, 8'd255, 8'd255, 1'b1, 8'h01);
		push_data(8'h00);
		push_byte(1'b1, 12'd4095, 12'd0, 8'd200, 8'd255, 8'd255, 1'b0, 8'h81);
		push_data(8'h7E);
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: configure(32'h0, 32'hFFFFFF, DEPTH_8BPP, 32'd1);
				1: configure($urandom, $urandom, DEPTH_16BPP, 32'd32767);
				2: configure($urandom, $urandom, DEPTH_SPARE, 32'd0);
				3: configure({8'd0, FOREGROUND_RESET}, {8'd0, BACKGROUND_RESET},
					DEPTH_32BPP, 32'd16384);
				default: configure($urandom, $urandom, DEPTH_BITS'($urandom_range(0, 3)),
					$urandom_range(1, 16384));
			endcase
			tx_steady = (phase == 3);
			rx_steady = (phase == 1) || (phase == 3);
			queued = 0;
			while (queued < BYTES_PER_PHASE)
				queued += queue_random_glyph();
			// receiver stalls long enough for the input side to back up
			if (phase == 1 || phase == 4)
				hold_req++;
			wait_idle();
		end

		if (mismatch_count == 0 && expected_writes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/gbce_pkg.sv
sv/gbce_front.sv
sv/gbce_queue.sv
sv/gbce_back.sv
sv/glyph_bitmap_color_expand_blit.sv
sv/gbce_checker.sv
test/glyph_bitmap_color_expand_blit_tb.sv
